// File: rtl/core/csh_pkg.sv
package csh_pkg;

  // deck geometry
  localparam int unsigned DECK_SIZE = 54;
  localparam int unsigned POS_W     = 6;
  localparam int unsigned DRAW_W    = 31;

  // divisor of the biased whole-deck choice
  localparam int unsigned BIAS_DIV  = 32'h8000_0000 / DECK_SIZE;
  localparam int unsigned DIV_W     = $clog2(BIAS_DIV + 1);
  localparam int unsigned CNT_W     = $clog2(DRAW_W);

  // queue between front and back
  localparam int unsigned QUEUE_DEPTH = 2;
  localparam int unsigned QPTR_W      = $clog2(QUEUE_DEPTH);
  localparam int unsigned QCNT_W      = $clog2(QUEUE_DEPTH + 1);

  // one swap command from front to back
  typedef struct packed {
    logic [POS_W-1:0] pos;
    logic [POS_W-1:0] partner;
    logic             last;
  } step_cmd_t;

  typedef enum logic [1:0] {
    F_IDLE,
    F_DIV,
    F_PUSH
  } front_state_t;

  typedef enum logic [1:0] {
    B_IDLE,
    B_READ,
    B_SWAP_I,
    B_SWAP_P
  } back_state_t;

endpackage

// File: rtl/core/csh_if.sv
interface csh_draw_if;
  import csh_pkg::*;

  logic              valid;
  logic              ready;
  logic [DRAW_W-1:0] random_draw;

  modport source (output valid, output random_draw, input ready);
  modport sink (input valid, input random_draw, output ready);
endinterface

interface csh_step_if;
  import csh_pkg::*;

  logic             valid;
  logic             ready;
  logic [POS_W-1:0] step_position;
  logic [POS_W-1:0] step_value;
  logic [POS_W-1:0] partner_position;
  logic [POS_W-1:0] partner_value;
  logic             pass_done;

  modport source (
    output valid, output step_position, output step_value,
    output partner_position, output partner_value, output pass_done,
    input ready
  );
  modport sink (
    input valid, input step_position, input step_value,
    input partner_position, input partner_value, input pass_done,
    output ready
  );
endinterface

// File: rtl/core/csh_front.sv
module csh_front (
  input  logic                clk,
  input  logic                rst,
  input  logic                cfg_we,
  input  logic                cfg_wdata,
  csh_draw_if.sink            draw_in,
  output logic                push,
  output csh_pkg::step_cmd_t  cmd,
  input  logic                full
);
  import csh_pkg::*;

  front_state_t      state;
  front_state_t      state_next;
  logic              unbiased_mode;
  logic [POS_W-1:0]  step_index;
  logic [DRAW_W-1:0] shreg;
  logic [DIV_W-1:0]  rem;
  logic [DIV_W-1:0]  divisor;
  logic [CNT_W-1:0]  cnt;

  logic [POS_W-1:0]  div_unb;
  logic [DIV_W:0]    trial;
  logic [DIV_W:0]    diff;
  logic              ge;
  logic [POS_W-1:0]  partner;
  logic              accept;

  assign accept = draw_in.valid && draw_in.ready;

  // mode register
  always_ff @(posedge clk) begin
    if (rst) begin
      unbiased_mode <= 1'b1;
    end else if (cfg_we) begin
      unbiased_mode <= cfg_wdata;
    end
  end

  // next state
  always_comb begin
    state_next = state;
    unique case (state)
      F_IDLE: begin
        if (accept) state_next = F_DIV;
      end
      F_DIV: begin
        if (cnt == '0) state_next = F_PUSH;
      end
      F_PUSH: begin
        if (!full) state_next = F_IDLE;
      end
      default: state_next = F_IDLE;
    endcase
  end

  // state outputs
  always_comb begin
    draw_in.ready = 1'b0;
    push          = 1'b0;
    unique case (state)
      F_IDLE:  draw_in.ready = 1'b1;
      F_DIV:   ;
      F_PUSH:  push = !full;
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= F_IDLE;
    end else begin
      state <= state_next;
    end
  end

  // one restoring division step per cycle
  assign div_unb = POS_W'(DECK_SIZE) - step_index + POS_W'(1);
  assign trial   = {rem, shreg[DRAW_W-1]};
  assign diff    = trial - {1'b0, divisor};
  assign ge      = trial >= {1'b0, divisor};

  always_ff @(posedge clk) begin
    if (accept) begin
      shreg   <= draw_in.random_draw;
      rem     <= '0;
      cnt     <= CNT_W'(DRAW_W - 1);
      divisor <= unbiased_mode ? DIV_W'(div_unb) : DIV_W'(BIAS_DIV);
    end else if (state == F_DIV) begin
      shreg <= {shreg[DRAW_W-2:0], ge};
      rem   <= ge ? diff[DIV_W-1:0] : trial[DIV_W-1:0];
      cnt   <= cnt - CNT_W'(1);
    end
  end

  // partner from remainder or clamped quotient
  always_comb begin
    if (unbiased_mode) begin
      partner = step_index + rem[POS_W-1:0];
    end else if (shreg >= DRAW_W'(DECK_SIZE)) begin
      partner = POS_W'(DECK_SIZE);
    end else begin
      partner = shreg[POS_W-1:0] + POS_W'(1);
    end
  end

  assign cmd.pos     = step_index;
  assign cmd.partner = partner;
  assign cmd.last    = step_index == POS_W'(DECK_SIZE);

  // step position advances per pushed command
  always_ff @(posedge clk) begin
    if (rst) begin
      step_index <= POS_W'(1);
    end else if (push) begin
      step_index <= cmd.last ? POS_W'(1) : step_index + POS_W'(1);
    end
  end

endmodule

// File: rtl/core/csh_queue.sv
module csh_queue (
  input  logic                clk,
  input  logic                rst,
  input  logic                push,
  input  csh_pkg::step_cmd_t  push_cmd,
  output logic                full,
  input  logic                pop,
  output csh_pkg::step_cmd_t  pop_cmd,
  output logic                empty
);
  import csh_pkg::*;

  step_cmd_t         entries [QUEUE_DEPTH];
  logic [QPTR_W-1:0] wr_ptr;
  logic [QPTR_W-1:0] rd_ptr;
  logic [QCNT_W-1:0] count;

  assign full    = count == QCNT_W'(QUEUE_DEPTH);
  assign empty   = count == '0;
  assign pop_cmd = entries[rd_ptr];

  // entry storage
  always_ff @(posedge clk) begin
    if (push) entries[wr_ptr] <= push_cmd;
  end

  // pointers and fill count
  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) wr_ptr <= wr_ptr + QPTR_W'(1);
      if (pop)  rd_ptr <= rd_ptr + QPTR_W'(1);
      if (push && !pop) begin
        count <= count + QCNT_W'(1);
      end else if (pop && !push) begin
        count <= count - QCNT_W'(1);
      end
    end
  end

endmodule

// File: rtl/core/csh_back.sv
module csh_back (
  input  logic                clk,
  input  logic                rst,
  input  csh_pkg::step_cmd_t  q_cmd,
  input  logic                q_empty,
  output logic                pop,
  csh_step_if.source          step_out
);
  import csh_pkg::*;

  back_state_t      state;
  back_state_t      state_next;
  step_cmd_t        cur;
  logic [POS_W-1:0] deck_mem [DECK_SIZE+1];
  logic             deck_vld [DECK_SIZE+1];
  logic [POS_W-1:0] rd_i;
  logic [POS_W-1:0] rd_p;
  logic             vld_i;
  logic             vld_p;
  logic             out_valid;

  logic [POS_W-1:0] val_i;
  logic [POS_W-1:0] val_p;
  logic             mem_we;
  logic [POS_W-1:0] mem_waddr;
  logic [POS_W-1:0] mem_wdata;
  logic             out_load;
  logic             out_free;

  assign out_free = !out_valid || step_out.ready;

  // entries never written read as their own position
  assign val_i = vld_i ? rd_i : cur.pos;
  assign val_p = vld_p ? rd_p : cur.partner;

  // next state
  always_comb begin
    state_next = state;
    unique case (state)
      B_IDLE: begin
        if (!q_empty) state_next = B_READ;
      end
      B_READ:   state_next = B_SWAP_I;
      B_SWAP_I: state_next = B_SWAP_P;
      B_SWAP_P: begin
        if (out_free) state_next = B_IDLE;
      end
      default: state_next = B_IDLE;
    endcase
  end

  // state outputs
  always_comb begin
    pop       = 1'b0;
    mem_we    = 1'b0;
    mem_waddr = cur.pos;
    mem_wdata = val_p;
    out_load  = 1'b0;
    unique case (state)
      B_IDLE:   pop = !q_empty;
      B_READ:   ;
      B_SWAP_I: mem_we = 1'b1;
      B_SWAP_P: begin
        mem_we    = 1'b1;
        mem_waddr = cur.partner;
        mem_wdata = val_i;
        out_load  = out_free;
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= B_IDLE;
    end else begin
      state <= state_next;
    end
  end

  // command register
  always_ff @(posedge clk) begin
    if (pop) cur <= q_cmd;
  end

  // deck memory, registered reads
  always_ff @(posedge clk) begin
    if (mem_we) deck_mem[mem_waddr] <= mem_wdata;
  end

  always_ff @(posedge clk) begin
    if (state == B_READ) begin
      rd_i <= deck_mem[cur.pos];
      rd_p <= deck_mem[cur.partner];
    end
  end

  // written flags, cleared by reset
  always_ff @(posedge clk) begin
    if (rst) begin
      for (int k = 0; k <= DECK_SIZE; k++) deck_vld[k] <= 1'b0;
      vld_i <= 1'b0;
      vld_p <= 1'b0;
    end else begin
      if (mem_we) deck_vld[mem_waddr] <= 1'b1;
      if (state == B_READ) begin
        vld_i <= deck_vld[cur.pos];
        vld_p <= deck_vld[cur.partner];
      end
    end
  end

  // output register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (out_load) begin
      out_valid <= 1'b1;
    end else if (step_out.ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (out_load) begin
      step_out.step_position    <= cur.pos;
      step_out.step_value       <= val_p;
      step_out.partner_position <= cur.partner;
      step_out.partner_value    <= val_i;
      step_out.pass_done        <= cur.last;
    end
  end

  assign step_out.valid = out_valid;

endmodule

// File: rtl/core/card_deck_shuffle_step.sv
// draws: a new draw is taken only once the previous one has passed the 31-step bit-serial
//   divider in the front part and its command is in the queue; the back part reads and swaps
//   the deck in states B_READ, B_SWAP_I and B_SWAP_P while the front part divides the next draw
// reset: deck is the identity, step position 1, unbiased mode on;
//   per-entry written flags stand in for the reset contents, no clearing pass
module card_deck_shuffle_step (
  input  logic        clk,
  input  logic        rst,
  input  logic        cfg_we,
  input  logic        cfg_wdata,
  csh_draw_if.sink    draw_in,
  csh_step_if.source  step_out
);
  import csh_pkg::*;

  step_cmd_t push_cmd;
  step_cmd_t pop_cmd;
  logic      push;
  logic      pop;
  logic      full;
  logic      empty;

  // draw intake and partner choice
  csh_front u_front (
    .clk       (clk),
    .rst       (rst),
    .cfg_we    (cfg_we),
    .cfg_wdata (cfg_wdata),
    .draw_in   (draw_in),
    .push      (push),
    .cmd       (push_cmd),
    .full      (full)
  );

  // command queue
  csh_queue u_queue (
    .clk      (clk),
    .rst      (rst),
    .push     (push),
    .push_cmd (push_cmd),
    .full     (full),
    .pop      (pop),
    .pop_cmd  (pop_cmd),
    .empty    (empty)
  );

  // deck swap and result
  csh_back u_back (
    .clk      (clk),
    .rst      (rst),
    .q_cmd    (pop_cmd),
    .q_empty  (empty),
    .pop      (pop),
    .step_out (step_out)
  );

endmodule

// File: bench/tb_top.sv
module tb_top;
  import csh_pkg::*;

  localparam int unsigned CYCLE_LIMIT = 300000;
  localparam int unsigned HOLD_CYCLES = 600;
  localparam int unsigned DRAIN_CYCLES = 40;
  localparam logic [DRAW_W-1:0] DRAW_MAX = 31'h7FFF_FFFF;
  // bucket width of the biased whole-deck pick
  localparam int unsigned PICK_DIV = 32'h8000_0000 / DECK_SIZE;
  localparam logic MODE_BIASED = 1'b0;
  localparam logic MODE_UNBIASED = 1'b1;

  typedef enum {
    RX_ALWAYS,
    RX_RANDOM,
    RX_PATTERN,
    RX_HOLD_OFF
  } rx_style_t;

  typedef struct {
    logic [POS_W-1:0] step_position;
    logic [POS_W-1:0] step_value;
    logic [POS_W-1:0] partner_position;
    logic [POS_W-1:0] partner_value;
    logic             pass_done;
  } swap_report_t;

  logic clk = 1'b0;
  logic rst;
  logic cfg_we;
  logic cfg_wdata;

  csh_draw_if draw_ch ();
  csh_step_if step_ch ();

  card_deck_shuffle_step dut (
    .clk      (clk),
    .rst      (rst),
    .cfg_we   (cfg_we),
    .cfg_wdata(cfg_wdata),
    .draw_in  (draw_ch),
    .step_out (step_ch)
  );

  always #2 clk = ~clk;

  // shadow deck and step position
  logic [POS_W-1:0] deck_model [1:DECK_SIZE];
  int unsigned      next_pos;
  logic             unbiased_model;

  logic [DRAW_W-1:0] pending_draws [$];
  swap_report_t      expected_swaps [$];

  int unsigned cycle_count = 0;
  int unsigned errors = 0;
  int unsigned gap_max = 0;
  rx_style_t   rx_style = RX_ALWAYS;

  int unsigned swaps_checked = 0;
  int unsigned passes_seen = 0;
  int unsigned self_swaps = 0;
  int unsigned clamped_picks = 0;
  int unsigned blocked_draws = 0;

  // apply one draw to the shadow deck and queue the expected report
  function automatic void shuffle_predict(input logic [DRAW_W-1:0] draw);
    int unsigned d;
    int unsigned pos;
    int unsigned partner;
    logic [POS_W-1:0] held;
    swap_report_t rep;
    d = {1'b0, draw};
    pos = next_pos;
    if (unbiased_model) begin
      partner = pos + d % (DECK_SIZE - pos + 1);
    end else begin
      partner = 1 + d / PICK_DIV;
      if (partner > DECK_SIZE) begin
        partner = DECK_SIZE;
        clamped_picks++;
      end
    end
    if (partner == pos) self_swaps++;
    held = deck_model[pos];
    deck_model[pos] = deck_model[partner];
    deck_model[partner] = held;
    rep.step_position = pos[POS_W-1:0];
    rep.step_value = deck_model[pos];
    rep.partner_position = partner[POS_W-1:0];
    rep.partner_value = deck_model[partner];
    rep.pass_done = (pos == DECK_SIZE);
    expected_swaps.push_back(rep);
    next_pos = (pos >= DECK_SIZE) ? 1 : pos + 1;
  endfunction

  // step position that a draw queued this many places ahead will meet
  function automatic int unsigned pos_at(input int unsigned ahead);
    return ((next_pos - 1 + ahead) % DECK_SIZE) + 1;
  endfunction

  // mix of full-range, small, near-top and one-bit-cleared draws
  function automatic logic [DRAW_W-1:0] pick_draw();
    int unsigned kind;
    kind = $urandom_range(0, 9);
    if (kind < 6) return DRAW_W'($urandom() & DRAW_MAX);
    if (kind < 7) return DRAW_W'($urandom_range(0, 255));
    if (kind < 9) return DRAW_MAX - DRAW_W'($urandom_range(0, 63));
    return DRAW_MAX ^ (31'd1 << $urandom_range(0, DRAW_W - 1));
  endfunction

  // cycle counter and timeout
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count == CYCLE_LIMIT) begin
      $display("timeout with %0d draws and %0d swaps outstanding",
               pending_draws.size(), expected_swaps.size());
      $display("== FAIL ==");
      $finish;
    end
  end

  // draw driver: bursts of random length with random gaps
  int unsigned burst_left = 0;
  int unsigned gap_left = 0;
  always @(posedge clk) begin
    logic offer;
    if (rst) begin
      draw_ch.valid <= 1'b0;
    end else begin
      offer = 1'b0;
      if (draw_ch.valid && draw_ch.ready) begin
        shuffle_predict(draw_ch.random_draw);
        void'(pending_draws.pop_front());
      end else if (draw_ch.valid) begin
        offer = 1'b1;
        if (!step_ch.ready) blocked_draws++;
      end
      if (!offer) begin
        if (gap_left > 0) begin
          gap_left--;
        end else if (pending_draws.size() > 0) begin
          offer = 1'b1;
          if (burst_left <= 1) begin
            burst_left = $urandom_range(1, 12);
            gap_left = $urandom_range(0, gap_max);
          end else begin
            burst_left--;
          end
        end
      end
      draw_ch.valid <= offer;
      if (offer) draw_ch.random_draw <= pending_draws[0];
    end
  end

  // result receiver: stall pattern per phase, one long hold-off
  int unsigned hold_left = 0;
  bit hold_taken = 1'b0;
  always @(posedge clk) begin
    if (rst) begin
      step_ch.ready <= 1'b0;
    end else begin
      if (rx_style == RX_HOLD_OFF && !hold_taken) begin
        hold_taken = 1'b1;
        hold_left = HOLD_CYCLES;
      end
      if (hold_left > 0) begin
        hold_left--;
        step_ch.ready <= 1'b0;
      end else begin
        case (rx_style)
          RX_ALWAYS: step_ch.ready <= 1'b1;
          RX_PATTERN: step_ch.ready <= (cycle_count % 7) >= 3;
          default: step_ch.ready <= $urandom_range(0, 99) >= 30;
        endcase
      end
    end
  end

  // monitor: compare each result transaction with the oldest expectation
  always @(posedge clk) begin
    swap_report_t want;
    if (!rst && step_ch.valid && step_ch.ready) begin
      if (expected_swaps.size() == 0) begin
        $error("unexpected result transaction at position %0d", step_ch.step_position);
        errors++;
      end else begin
        want = expected_swaps.pop_front();
        swaps_checked++;
        if (want.pass_done) passes_seen++;
        if (step_ch.step_position !== want.step_position) begin
          $error("step_position: expected %0d, got %0d",
                 want.step_position, step_ch.step_position);
          errors++;
        end
        if (step_ch.step_value !== want.step_value) begin
          $error("step_value: expected %0d, got %0d", want.step_value, step_ch.step_value);
          errors++;
        end
        if (step_ch.partner_position !== want.partner_position) begin
          $error("partner_position: expected %0d, got %0d",
                 want.partner_position, step_ch.partner_position);
          errors++;
        end
        if (step_ch.partner_value !== want.partner_value) begin
          $error("partner_value: expected %0d, got %0d",
                 want.partner_value, step_ch.partner_value);
          errors++;
        end
        if (step_ch.pass_done !== want.pass_done) begin
          $error("pass_done: expected %0d, got %0d", want.pass_done, step_ch.pass_done);
          errors++;
        end
      end
    end
  end

  // wait until every draw is taken and every swap reported
  task automatic wait_idle();
    while (pending_draws.size() > 0 || draw_ch.valid || expected_swaps.size() > 0)
      @(posedge clk);
    @(negedge clk);
  endtask

  task automatic write_mode(input logic mode);
    @(posedge clk);
    cfg_we <= 1'b1;
    cfg_wdata <= mode;
    @(posedge clk);
    cfg_we <= 1'b0;
    unbiased_model = mode;
    @(negedge clk);
  endtask

  // phases of random draws: mode, draw count, sender gap limit, receiver style
  localparam int NUM_PHASES = 6;
  localparam logic PH_MODE [NUM_PHASES] = '{MODE_UNBIASED, MODE_BIASED, MODE_UNBIASED,
                                             MODE_BIASED, MODE_UNBIASED, MODE_BIASED};
  localparam int PH_COUNT [NUM_PHASES] = '{100, 100, 60, 60, 120, 60};
  localparam int PH_GAP [NUM_PHASES] = '{20, 40, 0, 0, 40, 10};
  localparam rx_style_t PH_RX [NUM_PHASES] = '{RX_RANDOM, RX_PATTERN, RX_HOLD_OFF,
                                               RX_ALWAYS, RX_RANDOM, RX_RANDOM};

  initial begin
    int unsigned p;
    rst = 1'b1;
    cfg_we = 1'b0;
    cfg_wdata = 1'b0;
    draw_ch.valid = 1'b0;
    draw_ch.random_draw = '0;
    step_ch.ready = 1'b0;
    for (int k = 1; k <= DECK_SIZE; k++) deck_model[k] = k[POS_W-1:0];
    next_pos = 1;
    unbiased_model = MODE_UNBIASED;
    repeat (2) @(posedge clk);
    rst <= 1'b0;
    @(negedge clk);

    // unbiased corners: zero, all ones, alternating bits, furthest partner, self swap
    rx_style = RX_RANDOM;
    gap_max = 8;
    write_mode(MODE_UNBIASED);
    pending_draws.push_back('0);
    pending_draws.push_back(DRAW_MAX);
    pending_draws.push_back(31'd1);
    pending_draws.push_back(31'h2AAA_AAAA);
    pending_draws.push_back(31'h5555_5555);
    pending_draws.push_back(31'h4000_0000);
    pending_draws.push_back(DRAW_W'(DECK_SIZE - pos_at(6)));
    pending_draws.push_back(DRAW_W'((DECK_SIZE + 1 - pos_at(7)) * 1000));
    pending_draws.push_back(DRAW_W'((DECK_SIZE + 1 - pos_at(8)) * 12345 + 1));
    wait_idle();

    // biased corners: overflow clamp around the top, bucket edges, self swap
    write_mode(MODE_BIASED);
    pending_draws.push_back('0);
    pending_draws.push_back(DRAW_MAX);
    pending_draws.push_back(DRAW_W'(DECK_SIZE * PICK_DIV));
    pending_draws.push_back(DRAW_W'(DECK_SIZE * PICK_DIV - 1));
    pending_draws.push_back(DRAW_W'((pos_at(4) - 1) * PICK_DIV));
    pending_draws.push_back(DRAW_W'((pos_at(5) - 1) * PICK_DIV + PICK_DIV - 1));
    pending_draws.push_back(31'h4000_0000);
    pending_draws.push_back(DRAW_W'(PICK_DIV - 1));
    pending_draws.push_back(DRAW_W'(PICK_DIV));
    wait_idle();

    for (p = 0; p < NUM_PHASES; p++) begin
      write_mode(PH_MODE[p]);
      gap_max = PH_GAP[p];
      rx_style = PH_RX[p];
      for (int n = 0; n < PH_COUNT[p]; n++) pending_draws.push_back(pick_draw());
      wait_idle();
    end

    repeat (DRAIN_CYCLES) @(posedge clk);
    $display("checked %0d swaps over %0d full passes, %0d self swaps, %0d clamped picks",
             swaps_checked, passes_seen, self_swaps, clamped_picks);
    $display("draws held back %0d cycles while results were blocked", blocked_draws);
    if (errors == 0 && expected_swaps.size() == 0) begin
      $display("== PASS ==");
    end else begin
      $display("== FAIL ==");
    end
    $finish;
  end

endmodule

// File: filelist.f
rtl/core/csh_pkg.sv
rtl/core/csh_if.sv
rtl/core/csh_front.sv
rtl/core/csh_queue.sv
rtl/core/csh_back.sv
rtl/core/card_deck_shuffle_step.sv
bench/tb_top.sv
